// ===== rtl/u8dc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dc_pkg: shared types, range tables and helpers for the UTF-8 decoder
// Holds the fixed code point range tables used for character classification,
// the flag bit positions and the small helpers that test a code point
// against a table.
// ----------------------------------------------------------------------------
package u8dc_pkg;

  // Code point width and limits.
  localparam int unsigned CP_W      = 21;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] CASE_OFS    = 21'h000020;
  localparam logic [CP_W-1:0] CYR_OFS     = 21'h000050;
  localparam logic [CP_W-1:0] CYR_IO_UP   = 21'h000401;
  localparam logic [CP_W-1:0] CYR_IO_LOW  = 21'h000451;

  // Class flag bit positions.
  localparam int unsigned FLAG_W     = 12;
  localparam int unsigned FL_NULL    = 0;
  localparam int unsigned FL_ASCII   = 1;
  localparam int unsigned FL_NUMBER  = 2;
  localparam int unsigned FL_LETTER  = 3;
  localparam int unsigned FL_PUNCT   = 4;
  localparam int unsigned FL_CONTROL = 5;
  localparam int unsigned FL_CJK     = 6;
  localparam int unsigned FL_EMOJI   = 7;
  localparam int unsigned FL_SPACE   = 8;
  localparam int unsigned FL_PRINT   = 9;
  localparam int unsigned FL_LOWER   = 10;
  localparam int unsigned FL_UPPER   = 11;

  // Flags reported for a malformed character: null and control.
  localparam logic [FLAG_W-1:0] FLAGS_INVALID = 12'h021;

  // One inclusive code point range.
  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } span_t;

  localparam int unsigned NUM_N    = 33;
  localparam int unsigned CJK_N    = 14;
  localparam int unsigned LETTER_N = 18;
  localparam int unsigned PUNCT_N  = 11;
  localparam int unsigned EMOJI_N  = 26;
  localparam int unsigned SPACE_N  = 9;
  localparam int unsigned LOWER_N  = 7;
  localparam int unsigned UPPER_N  = 7;

  localparam span_t NUM_TAB [NUM_N] = '{
    '{21'h30, 21'h39}, '{21'h660, 21'h669}, '{21'h6F0, 21'h6F9},
    '{21'h966, 21'h96F}, '{21'h9E6, 21'h9EF}, '{21'hA66, 21'hA6F},
    '{21'hAE6, 21'hAEF}, '{21'hB66, 21'hB6F}, '{21'hBE6, 21'hBEF},
    '{21'hC66, 21'hC6F}, '{21'hCE6, 21'hCEF}, '{21'hD66, 21'hD6F},
    '{21'hE50, 21'hE59}, '{21'hED0, 21'hED9}, '{21'hF20, 21'hF29},
    '{21'h1040, 21'h1049}, '{21'h1090, 21'h1099}, '{21'h17E0, 21'h17E9},
    '{21'h1810, 21'h1819}, '{21'h1946, 21'h194F}, '{21'h19D0, 21'h19D9},
    '{21'h1A80, 21'h1A89}, '{21'h1A90, 21'h1A99}, '{21'h1B50, 21'h1B59},
    '{21'h1BB0, 21'h1BB9}, '{21'h1C40, 21'h1C49}, '{21'h1C50, 21'h1C59},
    '{21'hFF10, 21'hFF19}, '{21'h2160, 21'h2188}, '{21'h2460, 21'h2473},
    '{21'h24F5, 21'h24FE}, '{21'h2474, 21'h2487}, '{21'h2488, 21'h249B}
  };

  localparam span_t CJK_TAB [CJK_N] = '{
    '{21'h4E00, 21'h9FFF}, '{21'h3400, 21'h4DBF}, '{21'h20000, 21'h2A6DF},
    '{21'h2A700, 21'h2B73F}, '{21'h2B740, 21'h2B81F}, '{21'h2B820, 21'h2CEAF},
    '{21'h2CEB0, 21'h2EBEF}, '{21'h30000, 21'h3134F}, '{21'hF900, 21'hFAFF},
    '{21'h2F800, 21'h2FA1F}, '{21'h2E80, 21'h2EFF}, '{21'h2F00, 21'h2FDF},
    '{21'h31C0, 21'h31EF}, '{21'h3000, 21'h303F}
  };

  localparam span_t LETTER_TAB [LETTER_N] = '{
    '{21'h41, 21'h5A}, '{21'h61, 21'h7A}, '{21'hC0, 21'hD6},
    '{21'hD8, 21'hF6}, '{21'hF8, 21'hFF}, '{21'h400, 21'h481},
    '{21'h48A, 21'h4FF}, '{21'h500, 21'h52F}, '{21'h621, 21'h64A},
    '{21'h66E, 21'h66F}, '{21'h671, 21'h6D3}, '{21'h6D5, 21'h6D5},
    '{21'h5D0, 21'h5EA}, '{21'h5EF, 21'h5F2}, '{21'hAC00, 21'hD7A3},
    '{21'h1100, 21'h11FF}, '{21'h3131, 21'h318E}, '{21'hFFA1, 21'hFFDC}
  };

  localparam span_t PUNCT_TAB [PUNCT_N] = '{
    '{21'h21, 21'h2F}, '{21'h3A, 21'h40}, '{21'h5B, 21'h60},
    '{21'h7B, 21'h7E}, '{21'h3000, 21'h303F}, '{21'hFF00, 21'hFF0F},
    '{21'hFF1A, 21'hFF1F}, '{21'hFF3B, 21'hFF40}, '{21'hFF5B, 21'hFF65},
    '{21'h2000, 21'h206F}, '{21'h2E00, 21'h2E7F}
  };

  localparam span_t EMOJI_TAB [EMOJI_N] = '{
    '{21'h1F600, 21'h1F64F}, '{21'h1F300, 21'h1F5FF}, '{21'h1F680, 21'h1F6FF},
    '{21'h1F900, 21'h1F9FF}, '{21'h2600, 21'h26FF}, '{21'h2700, 21'h27BF},
    '{21'hFE0F, 21'hFE0F}, '{21'h200D, 21'h200D}, '{21'h1F1E6, 21'h1F1FF},
    '{21'h203C, 21'h203C}, '{21'h2049, 21'h2049}, '{21'h2122, 21'h2122},
    '{21'h2139, 21'h2139}, '{21'h2194, 21'h2195}, '{21'h21A9, 21'h21AA},
    '{21'h231A, 21'h231B}, '{21'h2328, 21'h2328}, '{21'h23CF, 21'h23CF},
    '{21'h23E9, 21'h23ED}, '{21'h23EF, 21'h23F0}, '{21'h23F3, 21'h23F3},
    '{21'h24C2, 21'h24C2}, '{21'h25AA, 21'h25AB}, '{21'h25B6, 21'h25B6},
    '{21'h25C0, 21'h25C0}, '{21'h25FB, 21'h25FE}
  };

  localparam span_t SPACE_TAB [SPACE_N] = '{
    '{21'h09, 21'h0D}, '{21'h20, 21'h20}, '{21'hA0, 21'hA0},
    '{21'h1680, 21'h1680}, '{21'h2000, 21'h200A}, '{21'h2028, 21'h2029},
    '{21'h202F, 21'h202F}, '{21'h205F, 21'h205F}, '{21'h3000, 21'h3000}
  };

  localparam span_t LOWER_TAB [LOWER_N] = '{
    '{21'h61, 21'h7A}, '{21'hE0, 21'hF6}, '{21'hF8, 21'hFF},
    '{21'h3B1, 21'h3C1}, '{21'h3C3, 21'h3CB}, '{21'h430, 21'h44F},
    '{21'h451, 21'h45F}
  };

  localparam span_t UPPER_TAB [UPPER_N] = '{
    '{21'h41, 21'h5A}, '{21'hC0, 21'hD6}, '{21'hD8, 21'hDF},
    '{21'h391, 21'h3A1}, '{21'h3A3, 21'h3AB}, '{21'h410, 21'h42F},
    '{21'h401, 21'h40F}
  };

  // Inclusive range test.
  function automatic logic in_rng(input logic [CP_W-1:0] cp,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // Table membership tests; every range is compared in parallel.
  function automatic logic is_number(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_N; i++) hit |= in_rng(cp, NUM_TAB[i].lo, NUM_TAB[i].hi);
    return hit;
  endfunction

  function automatic logic is_cjk(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CJK_N; i++) hit |= in_rng(cp, CJK_TAB[i].lo, CJK_TAB[i].hi);
    return hit;
  endfunction

  function automatic logic is_letter_tab(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < LETTER_N; i++) begin
      hit |= in_rng(cp, LETTER_TAB[i].lo, LETTER_TAB[i].hi);
    end
    return hit;
  endfunction

  function automatic logic is_punct(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < PUNCT_N; i++) begin
      hit |= in_rng(cp, PUNCT_TAB[i].lo, PUNCT_TAB[i].hi);
    end
    return hit;
  endfunction

  function automatic logic is_emoji(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < EMOJI_N; i++) begin
      hit |= in_rng(cp, EMOJI_TAB[i].lo, EMOJI_TAB[i].hi);
    end
    return hit;
  endfunction

  function automatic logic is_space(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SPACE_N; i++) begin
      hit |= in_rng(cp, SPACE_TAB[i].lo, SPACE_TAB[i].hi);
    end
    return hit;
  endfunction

  function automatic logic is_lower(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < LOWER_N; i++) begin
      hit |= in_rng(cp, LOWER_TAB[i].lo, LOWER_TAB[i].hi);
    end
    return hit;
  endfunction

  function automatic logic is_upper(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < UPPER_N; i++) begin
      hit |= in_rng(cp, UPPER_TAB[i].lo, UPPER_TAB[i].hi);
    end
    return hit;
  endfunction

endpackage

// ===== rtl/utf8_char_decode_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_char_decode_classify: UTF-8 character decoder and classifier
// Decodes one character per request, either from a UTF-8 byte sequence or
// from a raw code point, validates it and reports its class flags and its
// simple lower-case and upper-case mappings.
// ----------------------------------------------------------------------------
// The block accepts one character request per clock cycle while in_stall is
// low and returns one result per request, in order. An accepted request sits
// in the input register, and its result is captured in the result register,
// which drives the out_ ports. Decode, validation, range classification and
// case mapping are done in the logic between the two registers. The input
// side is stalled only when both registers hold requests and the result is
// stalled downstream.
// A malformed sequence or illegal code point yields valid_res 0, code point 0,
// byte count 0, mapped code points 0 and only the null and control flags.
module utf8_char_decode_classify
  import u8dc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Character request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [7:0]        in_byte_0,
  input  logic [7:0]        in_byte_1,
  input  logic [7:0]        in_byte_2,
  input  logic [7:0]        in_byte_3,
  input  logic [2:0]        in_seq_length,
  input  logic [31:0]       in_code_point_in,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_valid_res,
  output logic [CP_W-1:0]   out_code_point,
  output logic [2:0]        out_byte_count,
  output logic [FLAG_W-1:0] out_class_flags,
  output logic [CP_W-1:0]   out_lower_code_point,
  output logic [CP_W-1:0]   out_upper_code_point
);

  // Input register
  logic        s1_valid_r;
  logic        mode_r;
  logic [7:0]  b0_r, b1_r, b2_r, b3_r;
  logic [2:0]  len_r;
  logic [31:0] cpin_r;

  // Result register
  logic              out_valid_r;
  logic              res_ok_r;
  logic [CP_W-1:0]   res_cp_r;
  logic [2:0]        res_cnt_r;
  logic [FLAG_W-1:0] res_flags_r;
  logic [CP_W-1:0]   res_lower_r;
  logic [CP_W-1:0]   res_upper_r;

  // Decode results
  logic              ok_nxt;
  logic [CP_W-1:0]   cp_nxt;
  logic [2:0]        cnt_nxt;
  logic [FLAG_W-1:0] flags_nxt;
  logic [CP_W-1:0]   lower_nxt;
  logic [CP_W-1:0]   upper_nxt;

  logic s1_adv;
  logic in_take;

  // Handshake: the result register frees up when empty or when taken.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r <= in_mode;
      b0_r   <= in_byte_0;
      b1_r   <= in_byte_1;
      b2_r   <= in_byte_2;
      b3_r   <= in_byte_3;
      len_r  <= in_seq_length;
      cpin_r <= in_code_point_in;
    end
  end

  // Decode and validate the character.
  always_comb begin
    logic            form;
    logic [CP_W-1:0] c;
    logic [CP_W-1:0] minv;
    logic            cpin_legal;
    form       = 1'b0;
    c          = '0;
    minv       = '0;
    ok_nxt     = 1'b0;
    cp_nxt     = '0;
    cnt_nxt    = 3'd0;
    cpin_legal = (cpin_r <= 32'(CP_MAX)) &&
                 ((cpin_r < 32'(SURR_LO)) || (cpin_r > 32'(SURR_HI)));
    if (mode_r) begin
      if (cpin_legal) begin
        ok_nxt = 1'b1;
        cp_nxt = cpin_r[CP_W-1:0];
        if (cpin_r[CP_W-1:0] <= 21'h7F) begin
          cnt_nxt = 3'd1;
        end else if (cpin_r[CP_W-1:0] <= 21'h7FF) begin
          cnt_nxt = 3'd2;
        end else if (cpin_r[CP_W-1:0] <= 21'hFFFF) begin
          cnt_nxt = 3'd3;
        end else begin
          cnt_nxt = 3'd4;
        end
      end
    end else begin
      case (len_r)
        3'd1: begin
          form = !b0_r[7];
          c    = {13'd0, b0_r};
          minv = '0;
        end
        3'd2: begin
          form = (b0_r[7:5] == 3'b110) && (b1_r[7:6] == 2'b10);
          c    = {10'd0, b0_r[4:0], b1_r[5:0]};
          minv = 21'h80;
        end
        3'd3: begin
          form = (b0_r[7:4] == 4'b1110) && (b1_r[7:6] == 2'b10) &&
                 (b2_r[7:6] == 2'b10);
          c    = {5'd0, b0_r[3:0], b1_r[5:0], b2_r[5:0]};
          minv = 21'h800;
        end
        3'd4: begin
          form = (b0_r[7:3] == 5'b11110) && (b1_r[7:6] == 2'b10) &&
                 (b2_r[7:6] == 2'b10) && (b3_r[7:6] == 2'b10);
          c    = {b0_r[2:0], b1_r[5:0], b2_r[5:0], b3_r[5:0]};
          minv = 21'h10000;
        end
        default: begin
          form = 1'b0;
          c    = '0;
          minv = '0;
        end
      endcase
      if (form && (c <= CP_MAX) && ((c < SURR_LO) || (c > SURR_HI)) && (c >= minv)) begin
        ok_nxt  = 1'b1;
        cp_nxt  = c;
        cnt_nxt = len_r;
      end
    end
  end

  // Classify the decoded code point.
  always_comb begin
    logic cjk;
    logic ctl;
    logic nul;
    logic greek;
    cjk   = is_cjk(cp_nxt);
    nul   = (cp_nxt == '0);
    ctl   = (cp_nxt < 21'h20) || (cp_nxt == 21'h7F) || in_rng(cp_nxt, 21'h80, 21'h9F);
    greek = in_rng(cp_nxt, 21'h386, 21'h3CE) && (cp_nxt != 21'h387) &&
            (cp_nxt != 21'h38B) && (cp_nxt != 21'h38D);
    flags_nxt = '0;
    if (!ok_nxt) begin
      flags_nxt = FLAGS_INVALID;
    end else begin
      flags_nxt[FL_NULL]    = nul;
      flags_nxt[FL_ASCII]   = (cp_nxt <= 21'h7F);
      flags_nxt[FL_NUMBER]  = is_number(cp_nxt);
      flags_nxt[FL_LETTER]  = is_letter_tab(cp_nxt) || cjk || greek;
      flags_nxt[FL_PUNCT]   = is_punct(cp_nxt);
      flags_nxt[FL_CONTROL] = ctl;
      flags_nxt[FL_CJK]     = cjk;
      flags_nxt[FL_EMOJI]   = is_emoji(cp_nxt);
      flags_nxt[FL_SPACE]   = is_space(cp_nxt);
      flags_nxt[FL_PRINT]   = !nul && !ctl;
      flags_nxt[FL_LOWER]   = is_lower(cp_nxt);
      flags_nxt[FL_UPPER]   = is_upper(cp_nxt);
    end
  end

  // Simple case mappings for Latin-1, Greek and basic Cyrillic.
  always_comb begin
    logic to_low_shift;
    logic to_up_shift;
    to_low_shift = in_rng(cp_nxt, 21'h41, 21'h5A) || in_rng(cp_nxt, 21'hC0, 21'hD6) ||
                   in_rng(cp_nxt, 21'hD8, 21'hDE) || in_rng(cp_nxt, 21'h391, 21'h3A1) ||
                   in_rng(cp_nxt, 21'h3A3, 21'h3AB) || in_rng(cp_nxt, 21'h410, 21'h42F);
    to_up_shift  = in_rng(cp_nxt, 21'h61, 21'h7A) || in_rng(cp_nxt, 21'hE0, 21'hF6) ||
                   in_rng(cp_nxt, 21'hF8, 21'hFE) || in_rng(cp_nxt, 21'h3B1, 21'h3C1) ||
                   in_rng(cp_nxt, 21'h3C3, 21'h3CB) || in_rng(cp_nxt, 21'h430, 21'h44F);
    if (to_low_shift) begin
      lower_nxt = cp_nxt + CASE_OFS;
    end else if (cp_nxt == CYR_IO_UP) begin
      lower_nxt = CYR_IO_LOW;
    end else if (in_rng(cp_nxt, 21'h402, 21'h40F)) begin
      lower_nxt = cp_nxt + CYR_OFS;
    end else begin
      lower_nxt = cp_nxt;
    end
    if (to_up_shift) begin
      upper_nxt = cp_nxt - CASE_OFS;
    end else if (cp_nxt == CYR_IO_LOW) begin
      upper_nxt = CYR_IO_UP;
    end else if (in_rng(cp_nxt, 21'h452, 21'h45F)) begin
      upper_nxt = cp_nxt - CYR_OFS;
    end else begin
      upper_nxt = cp_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      res_ok_r    <= ok_nxt;
      res_cp_r    <= cp_nxt;
      res_cnt_r   <= cnt_nxt;
      res_flags_r <= flags_nxt;
      res_lower_r <= lower_nxt;
      res_upper_r <= upper_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_valid_res        = res_ok_r;
  assign out_code_point       = res_cp_r;
  assign out_byte_count       = res_cnt_r;
  assign out_class_flags      = res_flags_r;
  assign out_lower_code_point = res_lower_r;
  assign out_upper_code_point = res_upper_r;

endmodule

// ===== rtl/u8dc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dc_check: port-level checker for the UTF-8 decoder
// Watches the result channel and checks the consistency of each result
// with its validity and class flags.
// ----------------------------------------------------------------------------
module u8dc_check
  import u8dc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_valid_res,
  input logic [CP_W-1:0]   out_code_point,
  input logic [2:0]        out_byte_count,
  input logic [FLAG_W-1:0] out_class_flags,
  input logic [CP_W-1:0]   out_lower_code_point,
  input logic [CP_W-1:0]   out_upper_code_point
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point) &&
      $stable(out_class_flags) && $stable(out_valid_res))
    else $error("stalled result changed");

  // A malformed character is reported as the empty character.
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_code_point == '0 && out_byte_count == 3'd0 &&
      out_class_flags == FLAGS_INVALID && out_lower_code_point == '0 &&
      out_upper_code_point == '0)
    else $error("invalid result is not the empty character");

  // A valid character is a legal scalar value with a nonzero length.
  a_valid_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_byte_count != 3'd0 && out_byte_count <= 3'd4 &&
      out_code_point <= CP_MAX &&
      (out_code_point < SURR_LO || out_code_point > SURR_HI))
    else $error("valid result has an illegal code point or length");

  // Printable is exactly neither null nor control.
  a_print_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_class_flags[FL_PRINT] ==
      !(out_class_flags[FL_NULL] || out_class_flags[FL_CONTROL]))
    else $error("print flag inconsistent");

  // Only upper-case characters change under the lower-case mapping.
  a_lower_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res && out_lower_code_point != out_code_point |->
      out_class_flags[FL_UPPER])
    else $error("lower mapping changed a non upper-case character");

endmodule

bind utf8_char_decode_classify u8dc_check u_u8dc_check (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_valid_res        (out_valid_res),
  .out_code_point       (out_code_point),
  .out_byte_count       (out_byte_count),
  .out_class_flags      (out_class_flags),
  .out_lower_code_point (out_lower_code_point),
  .out_upper_code_point (out_upper_code_point)
);

// ===== sim/tb_utf8_char_decode_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_char_decode_classify: self-checking bench for the UTF-8 classifier
// Sends character requests (byte sequences and raw code points) through the
// valid/stall channel and predicts every result with an independent decoder
// and classifier. Results are matched in order, field by field. Both sides
// idle at random, and one phase holds the result side off to fill the block.
// ----------------------------------------------------------------------------
module tb_utf8_char_decode_classify;
  import u8dc_pkg::CP_W;
  import u8dc_pkg::FLAG_W;
  import u8dc_pkg::FL_NULL;
  import u8dc_pkg::FL_ASCII;
  import u8dc_pkg::FL_NUMBER;
  import u8dc_pkg::FL_LETTER;
  import u8dc_pkg::FL_PUNCT;
  import u8dc_pkg::FL_CONTROL;
  import u8dc_pkg::FL_CJK;
  import u8dc_pkg::FL_EMOJI;
  import u8dc_pkg::FL_SPACE;
  import u8dc_pkg::FL_PRINT;
  import u8dc_pkg::FL_LOWER;
  import u8dc_pkg::FL_UPPER;

  // One character request as offered on the input channel.
  typedef struct packed {
    logic            mode;
    logic [3:0][7:0] seq_bytes;
    logic [2:0]      seq_len;
    logic [31:0]     cp_in;
  } char_req_t;

  // One decoded and classified character.
  typedef struct packed {
    logic              valid_res;
    logic [CP_W-1:0]   code_point;
    logic [2:0]        byte_count;
    logic [FLAG_W-1:0] class_flags;
    logic [CP_W-1:0]   lower_cp;
    logic [CP_W-1:0]   upper_cp;
  } char_res_t;

  localparam logic MODE_BYTES = 1'b0;
  localparam logic MODE_CODE  = 1'b1;
  localparam int   RANDOM_CHARS   = 1000;
  localparam int   PRESSURE_CHARS = 40;
  localparam int   HOLD_CYCLES    = 80;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic [7:0]        in_byte_0;
  logic [7:0]        in_byte_1;
  logic [7:0]        in_byte_2;
  logic [7:0]        in_byte_3;
  logic [2:0]        in_seq_length;
  logic [31:0]       in_code_point_in;
  logic              out_valid;
  logic              out_stall;
  logic              out_valid_res;
  logic [CP_W-1:0]   out_code_point;
  logic [2:0]        out_byte_count;
  logic [FLAG_W-1:0] out_class_flags;
  logic [CP_W-1:0]   out_lower_code_point;
  logic [CP_W-1:0]   out_upper_code_point;

  char_res_t expected_chars[$];
  char_res_t want_res;
  int        mismatch_count = 0;
  int        tx_gap_pct;
  int        rx_stall_pct;
  // Hold-off requests from the tests and the ones the result side has served.
  int        hold_req;
  int        hold_ack;
  int        hold_left;

  utf8_char_decode_classify dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_byte_0            (in_byte_0),
    .in_byte_1            (in_byte_1),
    .in_byte_2            (in_byte_2),
    .in_byte_3            (in_byte_3),
    .in_seq_length        (in_seq_length),
    .in_code_point_in     (in_code_point_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_valid_res        (out_valid_res),
    .out_code_point       (out_code_point),
    .out_byte_count       (out_byte_count),
    .out_class_flags      (out_class_flags),
    .out_lower_code_point (out_lower_code_point),
    .out_upper_code_point (out_upper_code_point)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character class ranges, all bounds inclusive.
  // ---------------------------------------------------------------------------
  function automatic bit sp(input logic [CP_W-1:0] c, input int lo, input int hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic bit hit_number(input logic [CP_W-1:0] c);
    return sp(c, 'h30, 'h39) || sp(c, 'h660, 'h669) || sp(c, 'h6F0, 'h6F9) ||
           sp(c, 'h966, 'h96F) || sp(c, 'h9E6, 'h9EF) || sp(c, 'hA66, 'hA6F) ||
           sp(c, 'hAE6, 'hAEF) || sp(c, 'hB66, 'hB6F) || sp(c, 'hBE6, 'hBEF) ||
           sp(c, 'hC66, 'hC6F) || sp(c, 'hCE6, 'hCEF) || sp(c, 'hD66, 'hD6F) ||
           sp(c, 'hE50, 'hE59) || sp(c, 'hED0, 'hED9) || sp(c, 'hF20, 'hF29) ||
           sp(c, 'h1040, 'h1049) || sp(c, 'h1090, 'h1099) || sp(c, 'h17E0, 'h17E9) ||
           sp(c, 'h1810, 'h1819) || sp(c, 'h1946, 'h194F) || sp(c, 'h19D0, 'h19D9) ||
           sp(c, 'h1A80, 'h1A89) || sp(c, 'h1A90, 'h1A99) || sp(c, 'h1B50, 'h1B59) ||
           sp(c, 'h1BB0, 'h1BB9) || sp(c, 'h1C40, 'h1C49) || sp(c, 'h1C50, 'h1C59) ||
           sp(c, 'hFF10, 'hFF19) || sp(c, 'h2160, 'h2188) || sp(c, 'h2460, 'h249B) ||
           sp(c, 'h24F5, 'h24FE);
  endfunction

  function automatic bit hit_cjk(input logic [CP_W-1:0] c);
    return sp(c, 'h4E00, 'h9FFF) || sp(c, 'h3400, 'h4DBF) || sp(c, 'h20000, 'h2A6DF) ||
           sp(c, 'h2A700, 'h2EBEF) || sp(c, 'h30000, 'h3134F) || sp(c, 'hF900, 'hFAFF) ||
           sp(c, 'h2F800, 'h2FA1F) || sp(c, 'h2E80, 'h2FDF) || sp(c, 'h31C0, 'h31EF) ||
           sp(c, 'h3000, 'h303F);
  endfunction

  function automatic bit hit_letter(input logic [CP_W-1:0] c);
    return sp(c, 'h41, 'h5A) || sp(c, 'h61, 'h7A) || sp(c, 'hC0, 'hD6) ||
           sp(c, 'hD8, 'hF6) || sp(c, 'hF8, 'hFF) || sp(c, 'h400, 'h481) ||
           sp(c, 'h48A, 'h52F) || sp(c, 'h621, 'h64A) || sp(c, 'h66E, 'h66F) ||
           sp(c, 'h671, 'h6D3) || sp(c, 'h6D5, 'h6D5) || sp(c, 'h5D0, 'h5EA) ||
           sp(c, 'h5EF, 'h5F2) || sp(c, 'hAC00, 'hD7A3) || sp(c, 'h1100, 'h11FF) ||
           sp(c, 'h3131, 'h318E) || sp(c, 'hFFA1, 'hFFDC);
  endfunction

  function automatic bit hit_punct(input logic [CP_W-1:0] c);
    return sp(c, 'h21, 'h2F) || sp(c, 'h3A, 'h40) || sp(c, 'h5B, 'h60) ||
           sp(c, 'h7B, 'h7E) || sp(c, 'h3000, 'h303F) || sp(c, 'hFF00, 'hFF0F) ||
           sp(c, 'hFF1A, 'hFF1F) || sp(c, 'hFF3B, 'hFF40) || sp(c, 'hFF5B, 'hFF65) ||
           sp(c, 'h2000, 'h206F) || sp(c, 'h2E00, 'h2E7F);
  endfunction

  function automatic bit hit_emoji(input logic [CP_W-1:0] c);
    return sp(c, 'h1F300, 'h1F64F) || sp(c, 'h1F680, 'h1F6FF) ||
           sp(c, 'h1F900, 'h1F9FF) || sp(c, 'h2600, 'h27BF) || sp(c, 'hFE0F, 'hFE0F) ||
           sp(c, 'h200D, 'h200D) || sp(c, 'h1F1E6, 'h1F1FF) || sp(c, 'h203C, 'h203C) ||
           sp(c, 'h2049, 'h2049) || sp(c, 'h2122, 'h2122) || sp(c, 'h2139, 'h2139) ||
           sp(c, 'h2194, 'h2195) || sp(c, 'h21A9, 'h21AA) || sp(c, 'h231A, 'h231B) ||
           sp(c, 'h2328, 'h2328) || sp(c, 'h23CF, 'h23CF) || sp(c, 'h23E9, 'h23ED) ||
           sp(c, 'h23EF, 'h23F0) || sp(c, 'h23F3, 'h23F3) || sp(c, 'h24C2, 'h24C2) ||
           sp(c, 'h25AA, 'h25AB) || sp(c, 'h25B6, 'h25B6) || sp(c, 'h25C0, 'h25C0) ||
           sp(c, 'h25FB, 'h25FE);
  endfunction

  function automatic bit hit_space(input logic [CP_W-1:0] c);
    return sp(c, 'h09, 'h0D) || sp(c, 'h20, 'h20) || sp(c, 'hA0, 'hA0) ||
           sp(c, 'h1680, 'h1680) || sp(c, 'h2000, 'h200A) || sp(c, 'h2028, 'h2029) ||
           sp(c, 'h202F, 'h202F) || sp(c, 'h205F, 'h205F) || sp(c, 'h3000, 'h3000);
  endfunction

  function automatic bit hit_lower(input logic [CP_W-1:0] c);
    return sp(c, 'h61, 'h7A) || sp(c, 'hE0, 'hF6) || sp(c, 'hF8, 'hFF) ||
           sp(c, 'h3B1, 'h3C1) || sp(c, 'h3C3, 'h3CB) || sp(c, 'h430, 'h44F) ||
           sp(c, 'h451, 'h45F);
  endfunction

  function automatic bit hit_upper(input logic [CP_W-1:0] c);
    return sp(c, 'h41, 'h5A) || sp(c, 'hC0, 'hD6) || sp(c, 'hD8, 'hDF) ||
           sp(c, 'h391, 'h3A1) || sp(c, 'h3A3, 'h3AB) || sp(c, 'h401, 'h42F);
  endfunction

  // Simple case folding: Latin-1, Greek and basic Cyrillic only.
  function automatic logic [CP_W-1:0] fold_lower(input logic [CP_W-1:0] c);
    if (sp(c, 'h41, 'h5A) || sp(c, 'hC0, 'hD6) || sp(c, 'hD8, 'hDE) ||
        sp(c, 'h391, 'h3A1) || sp(c, 'h3A3, 'h3AB) || sp(c, 'h410, 'h42F)) begin
      return c + 21'h20;
    end
    if (c == 21'h401) return 21'h451;
    if (sp(c, 'h402, 'h40F)) return c + 21'h50;
    return c;
  endfunction

  function automatic logic [CP_W-1:0] fold_upper(input logic [CP_W-1:0] c);
    if (sp(c, 'h61, 'h7A) || sp(c, 'hE0, 'hF6) || sp(c, 'hF8, 'hFE) ||
        sp(c, 'h3B1, 'h3C1) || sp(c, 'h3C3, 'h3CB) || sp(c, 'h430, 'h44F)) begin
      return c - 21'h20;
    end
    if (c == 21'h451) return 21'h401;
    if (sp(c, 'h452, 'h45F)) return c - 21'h50;
    return c;
  endfunction

  // A scalar value is legal when it is in range and not a surrogate.
  function automatic bit legal_scalar(input logic [31:0] c);
    return (c <= 32'h10FFFF) && ((c < 32'hD800) || (c > 32'hDFFF));
  endfunction

  function automatic logic [2:0] utf8_len(input logic [31:0] c);
    if (c <= 32'h7F) return 3'd1;
    if (c <= 32'h7FF) return 3'd2;
    if (c <= 32'hFFFF) return 3'd3;
    return 3'd4;
  endfunction

  // ---------------------------------------------------------------------------
  // Decode, validate and classify one character request.
  // ---------------------------------------------------------------------------
  function automatic char_res_t decode_classify(input char_req_t r);
    char_res_t       e;
    logic [31:0]     c;
    logic [31:0]     floor_v;
    logic [7:0]      b0, b1, b2, b3;
    logic [CP_W-1:0] cp;
    bit              formed, cjk, ctl, nul;
    e = '0;
    b0 = r.seq_bytes[0];
    b1 = r.seq_bytes[1];
    b2 = r.seq_bytes[2];
    b3 = r.seq_bytes[3];
    if (r.mode == MODE_CODE) begin
      if (legal_scalar(r.cp_in)) begin
        e.valid_res  = 1'b1;
        e.code_point = r.cp_in[CP_W-1:0];
        e.byte_count = utf8_len(r.cp_in);
      end
    end else begin
      formed = 1'b0;
      c = '0;
      floor_v = '0;
      case (r.seq_len)
        3'd1: begin
          formed = (b0 <= 8'h7F);
          c = {24'h0, b0};
        end
        3'd2: begin
          formed = (b0[7:5] == 3'b110) && (b1[7:6] == 2'b10);
          c = {21'h0, b0[4:0], b1[5:0]};
          floor_v = 32'h80;
        end
        3'd3: begin
          formed = (b0[7:4] == 4'b1110) && (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
          c = {16'h0, b0[3:0], b1[5:0], b2[5:0]};
          floor_v = 32'h800;
        end
        3'd4: begin
          formed = (b0[7:3] == 5'b11110) && (b1[7:6] == 2'b10) &&
                   (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
          c = {11'h0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
          floor_v = 32'h10000;
        end
        default: ;
      endcase
      // Overlong forms fall below the smallest value of their length.
      if (formed && legal_scalar(c) && (c >= floor_v)) begin
        e.valid_res  = 1'b1;
        e.code_point = c[CP_W-1:0];
        e.byte_count = r.seq_len;
      end
    end

    cp = e.code_point;
    if (!e.valid_res) begin
      e.class_flags[FL_NULL]    = 1'b1;
      e.class_flags[FL_CONTROL] = 1'b1;
    end else begin
      cjk = hit_cjk(cp);
      ctl = (cp < 21'h20) || (cp == 21'h7F) || sp(cp, 'h80, 'h9F);
      nul = (cp == '0);
      e.class_flags[FL_NULL]    = nul;
      e.class_flags[FL_ASCII]   = (cp <= 21'h7F);
      e.class_flags[FL_NUMBER]  = hit_number(cp);
      // Greek letters are a range with three holes.
      e.class_flags[FL_LETTER]  = hit_letter(cp) || cjk ||
                                  (sp(cp, 'h386, 'h3CE) && cp != 21'h387 &&
                                   cp != 21'h38B && cp != 21'h38D);
      e.class_flags[FL_PUNCT]   = hit_punct(cp);
      e.class_flags[FL_CONTROL] = ctl;
      e.class_flags[FL_CJK]     = cjk;
      e.class_flags[FL_EMOJI]   = hit_emoji(cp);
      e.class_flags[FL_SPACE]   = hit_space(cp);
      e.class_flags[FL_PRINT]   = !nul && !ctl;
      e.class_flags[FL_LOWER]   = hit_lower(cp);
      e.class_flags[FL_UPPER]   = hit_upper(cp);
    end
    e.lower_cp = fold_lower(cp);
    e.upper_cp = fold_upper(cp);
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders. Fields the block must ignore are filled with noise.
  // ---------------------------------------------------------------------------
  function automatic char_req_t utf8_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
    char_req_t r;
    r.mode      = MODE_BYTES;
    r.seq_bytes = {b3, b2, b1, b0};
    r.seq_len   = len;
    r.cp_in     = $urandom;
    return r;
  endfunction

  function automatic char_req_t raw_code(input logic [31:0] c);
    char_req_t r;
    r.mode      = MODE_CODE;
    r.seq_bytes = $urandom;
    r.seq_len   = 3'($urandom_range(0, 7));
    r.cp_in     = c;
    return r;
  endfunction

  // Encode with a forced length; a length of zero picks the shortest form.
  function automatic char_req_t encode_char(input logic [CP_W-1:0] c, input int n);
    char_req_t  r;
    logic [2:0] len;
    len = (n == 0) ? utf8_len({11'h0, c}) : n[2:0];
    r = utf8_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), len);
    case (len)
      3'd1: r.seq_bytes[0] = {1'b0, c[6:0]};
      3'd2: begin
        r.seq_bytes[0] = {3'b110, c[10:6]};
        r.seq_bytes[1] = {2'b10, c[5:0]};
      end
      3'd3: begin
        r.seq_bytes[0] = {4'b1110, c[15:12]};
        r.seq_bytes[1] = {2'b10, c[11:6]};
        r.seq_bytes[2] = {2'b10, c[5:0]};
      end
      default: begin
        r.seq_bytes[0] = {5'b11110, c[20:18]};
        r.seq_bytes[1] = {2'b10, c[17:12]};
        r.seq_bytes[2] = {2'b10, c[11:6]};
        r.seq_bytes[3] = {2'b10, c[5:0]};
      end
    endcase
    return r;
  endfunction

  // Code points weighted toward the class tables and the legality edges.
  function automatic logic [CP_W-1:0] pick_code();
    case ($urandom_range(0, 9))
      0: return CP_W'($urandom_range('h0, 'h7F));
      1: return CP_W'($urandom_range('h80, 'h7FF));
      2: return CP_W'($urandom_range('h800, 'hFFFF));
      3: return CP_W'($urandom_range('h10000, 'h10FFFF));
      4: return CP_W'($urandom_range('h370, 'h52F));
      5: return CP_W'($urandom_range('h2000, 'h27BF));
      6: return CP_W'($urandom_range('h3000, 'h9FFF));
      7: return CP_W'($urandom_range('hFF00, 'hFFFF));
      8: return CP_W'($urandom_range('h1F100, 'h1F9FF));
      default: begin
        if ($urandom_range(0, 1)) return CP_W'($urandom_range('hD7FE, 'hE001));
        return CP_W'($urandom_range('h10FFFE, 'h1FFFFF));
      end
    endcase
  endfunction

  // Mostly well-formed sequences, then broken ones, noise and raw code points.
  function automatic char_req_t random_char();
    char_req_t       r;
    logic [CP_W-1:0] c;
    int              roll, k, j;
    roll = $urandom_range(0, 99);
    c = pick_code();
    if (roll < 55) begin
      r = encode_char(c, 0);
    end else if (roll < 67) begin
      r = encode_char(c, 0);
      k = $urandom_range(0, 3);
      j = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: r = encode_char(c, (utf8_len({11'h0, c}) < 4) ? utf8_len({11'h0, c}) + 1 : 4);
        1: r.seq_bytes[k][j] = ~r.seq_bytes[k][j];
        2: r.seq_len = 3'($urandom_range(0, 7));
        default: r.seq_bytes[$urandom_range(1, 3)][7:6] = 2'($urandom_range(0, 3));
      endcase
    end else if (roll < 72) begin
      r = utf8_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     3'($urandom_range(0, 7)));
    end else if (roll < 92) begin
      r = raw_code({11'h0, c});
    end else begin
      r = raw_code($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: optional idle cycles, then hold the request until accepted.
  // ---------------------------------------------------------------------------
  task automatic send_char(input char_req_t r);
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_gap_pct) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= r.mode;
    in_byte_0        <= r.seq_bytes[0];
    in_byte_1        <= r.seq_bytes[1];
    in_byte_2        <= r.seq_bytes[2];
    in_byte_3        <= r.seq_bytes[3];
    in_seq_length    <= r.seq_len;
    in_code_point_in <= r.cp_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_chars.push_back(decode_classify(r));
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, or a counted hold-off when one is requested.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_ack  <= hold_req;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_res = expected_chars.pop_front();
        if (out_valid_res !== want_res.valid_res)
          report_mismatch($sformatf("valid_res got %0h expected %0h",
                                    out_valid_res, want_res.valid_res));
        if (out_code_point !== want_res.code_point)
          report_mismatch($sformatf("code_point got %0h expected %0h",
                                    out_code_point, want_res.code_point));
        if (out_byte_count !== want_res.byte_count)
          report_mismatch($sformatf("byte_count got %0h expected %0h (cp %0h)",
                                    out_byte_count, want_res.byte_count,
                                    want_res.code_point));
        if (out_class_flags !== want_res.class_flags)
          report_mismatch($sformatf("class_flags got %03h expected %03h (cp %0h)",
                                    out_class_flags, want_res.class_flags,
                                    want_res.code_point));
        if (out_lower_code_point !== want_res.lower_cp)
          report_mismatch($sformatf("lower_code_point got %0h expected %0h",
                                    out_lower_code_point, want_res.lower_cp));
        if (out_upper_code_point !== want_res.upper_cp)
          report_mismatch($sformatf("upper_code_point got %0h expected %0h",
                                    out_upper_code_point, want_res.upper_cp));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // An empty sequence and lengths beyond four bytes are both malformed.
  task automatic test_empty_and_length();
    send_char(utf8_bytes(8'h41, 8'h80, 8'h80, 8'h80, 3'd0));
    send_char(utf8_bytes(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd5));
    send_char(utf8_bytes(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd6));
    send_char(utf8_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
  endtask

  // Well-formed sequences of each length, overlong forms, bad continuation and lead
  // bytes, and the surrogate and upper limit edges.
  task automatic test_byte_sequences();
    send_char(utf8_bytes(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1));
    send_char(utf8_bytes(8'h7F, 8'h00, 8'h00, 8'h00, 3'd1));
    send_char(utf8_bytes(8'h80, 8'h00, 8'h00, 8'h00, 3'd1));
    send_char(utf8_bytes(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2));
    send_char(utf8_bytes(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2));
    send_char(utf8_bytes(8'hC3, 8'h29, 8'h00, 8'h00, 3'd2));
    send_char(utf8_bytes(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd3));
    send_char(utf8_bytes(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3));
    send_char(utf8_bytes(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3));
    send_char(utf8_bytes(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd4));
    send_char(utf8_bytes(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4));
    send_char(utf8_bytes(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4));
    send_char(utf8_bytes(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4));
  endtask

  // Raw code points: zero, the limit and just past it, surrogates, all ones,
  // and the Cyrillic letters with irregular case mapping.
  task automatic test_code_points();
    send_char(raw_code(32'h0));
    send_char(raw_code(32'h10FFFF));
    send_char(raw_code(32'h110000));
    send_char(raw_code(32'hD800));
    send_char(raw_code(32'hDFFF));
    send_char(raw_code(32'hFFFFFFFF));
    send_char(raw_code(32'h401));
    send_char(raw_code(32'h451));
  endtask

  // Random characters; a middle stretch runs with no idling on either side.
  task automatic test_random_chars();
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      if (i == RANDOM_CHARS * 2 / 5) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else if (i == RANDOM_CHARS * 3 / 5) begin
        tx_gap_pct   = 36;
        rx_stall_pct = 36;
      end
      send_char(random_char());
    end
  endtask

  // Hold the result side off while requests keep coming so the input stalls.
  task automatic test_backpressure();
    tx_gap_pct = 0;
    hold_req++;
    for (int i = 0; i < PRESSURE_CHARS; i++) send_char(random_char());
    tx_gap_pct = 36;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    tx_gap_pct       = 36;
    rx_stall_pct     = 36;
    hold_req         = 0;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_mode          <= MODE_BYTES;
    in_byte_0        <= '0;
    in_byte_1        <= '0;
    in_byte_2        <= '0;
    in_byte_3        <= '0;
    in_seq_length    <= '0;
    in_code_point_in <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_length();
    test_byte_sequences();
    test_code_points();
    test_random_chars();
    test_backpressure();
    in_valid <= 1'b0;

    // Drain, then keep watching the result port for strays.
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u8dc_pkg.sv
rtl/utf8_char_decode_classify.sv
rtl/u8dc_check.sv
sim/tb_utf8_char_decode_classify.sv
